[design/homogeneous_vertex_transform_defines.svh]
// Assertion macros shared by the vertex transform RTL.
// Depends on a clock named clock and a reset named reset in the using scope.
`ifndef HOMOGENEOUS_VERTEX_TRANSFORM_DEFINES_SVH
`define HOMOGENEOUS_VERTEX_TRANSFORM_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HVT_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
   else $error("vertex transform assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define HVT_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
   else $error("vertex transform assertion failed");

`endif

[design/hvt_pkg.sv]
// Package for the homogeneous vertex transform: widths, codes and pipeline types.
// Depends on nothing; used by the interfaces, the top level and the testbench.
`timescale 1ns / 1ps

package hvt_pkg;

   localparam int FRAC_BITS = 16;
   localparam int DATA_W    = 32;
   localparam int PROD_W    = 2 * DATA_W;
   // Three full products plus the scaled translation stay below 2^64 in magnitude.
   localparam int SUM_W     = PROD_W + 2;
   localparam int COORD_W   = SUM_W - FRAC_BITS;
   localparam int DIV_STEPS = DATA_W;
   localparam int NUM_COEFF = 16;

   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_XFORM = 1'b1;

   localparam logic [DATA_W-1:0] POS_LIMIT = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic [DATA_W-1:0] NEG_LIMIT = {1'b1, {(DATA_W-1){1'b0}}};

   typedef logic signed [DATA_W-1:0]  data_type;
   typedef logic signed [PROD_W-1:0]  prod_type;
   typedef logic signed [SUM_W-1:0]   sum_type;
   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic [COORD_W-1:0]        mag_type;

   // State of one coordinate lane inside the restoring divider.
   typedef struct packed {
      mag_type           rem;
      logic [DATA_W-1:0] nlo;
      logic [DATA_W-1:0] q;
      logic              neg;
      logic              ovf;
   } div_type;

   // Per-item data that rides along with the divider lanes.
   typedef struct packed {
      mag_type                 dmag;
      logic                    wz;
      logic [2:0][DATA_W-1:0]  clampv;
      logic                    csat;
   } side_type;

endpackage

[design/hvt_ifs.sv]
// Valid/ready channel interfaces for the vertex transform request and response.
// Depends on hvt_pkg for field types.
`timescale 1ns / 1ps

interface hvt_req_if;
   logic               valid;
   logic               ready;
   logic               mode;
   logic [3:0]         entry_index;
   hvt_pkg::data_type  entry_value;
   hvt_pkg::data_type  in_x;
   hvt_pkg::data_type  in_y;
   hvt_pkg::data_type  in_z;

   modport source (output valid, mode, entry_index, entry_value, in_x, in_y, in_z,
                   input ready);
   modport sink   (input valid, mode, entry_index, entry_value, in_x, in_y, in_z,
                   output ready);
endinterface

interface hvt_rsp_if;
   logic               valid;
   logic               ready;
   hvt_pkg::data_type  out_x;
   hvt_pkg::data_type  out_y;
   hvt_pkg::data_type  out_z;
   logic               w_was_zero;
   logic               saturated;

   modport source (output valid, out_x, out_y, out_z, w_was_zero, saturated,
                   input ready);
   modport sink   (input valid, out_x, out_y, out_z, w_was_zero, saturated,
                   output ready);
endinterface

[design/homogeneous_vertex_transform.sv]
// Top level of the homogeneous vertex transform with perspective divide.
// Depends on hvt_pkg, hvt_ifs.sv and homogeneous_vertex_transform_defines.svh.
`timescale 1ns / 1ps
`include "homogeneous_vertex_transform_defines.svh"

// A transform item (mode 1) multiplies the point (x, y, z, 1) as a row vector by the
// stored 4x4 Q16.16 matrix, divides x, y and z by the resulting w, and returns one
// result item; if w is zero the coordinates pass undivided and w_was_zero is set.
// Any clamp to the 32-bit range sets saturated. A load item (mode 0) writes one
// matrix entry, row*4+column, and returns nothing; a transform accepted in the very
// next cycle already sees the new entry. The matrix is all zero after reset. The
// block accepts one item per clock unless the response side stalls; then the whole
// pipeline holds, so no item is lost or repeated, and idle slots left by load items
// are not squeezed out. A transform's result passes through the product,
// partial-sum, full-sum and sign registers, 32 stages of a pipelined restoring
// divider (one quotient bit per stage) and the output register.
module homogeneous_vertex_transform (
   input  logic       clock,
   input  logic       reset,
   hvt_req_if.sink    req_chan,
   hvt_rsp_if.source  rsp_chan
);

   localparam int CW = hvt_pkg::COORD_W;
   localparam int NS = hvt_pkg::DIV_STEPS;

   // The pipeline moves as one unit whenever the output register can take a value.
   logic adv;
   logic req_acc;
   assign adv              = !rsp_chan.valid || rsp_chan.ready;
   assign req_chan.ready   = adv;
   assign req_acc          = req_chan.valid && req_chan.ready;

   // Matrix store; entries 0 to 11 feed the multipliers at fixed places, 12 to 15 the translation row.
   hvt_pkg::data_type coeff_ff [hvt_pkg::NUM_COEFF];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < hvt_pkg::NUM_COEFF; i++) begin
            coeff_ff[i] <= '0;
         end
      end else if (req_acc && req_chan.mode == hvt_pkg::MODE_LOAD) begin
         coeff_ff[req_chan.entry_index] <= req_chan.entry_value;
      end
   end

   // Stage 1: the twelve point-by-coefficient products and the translation row.
   hvt_pkg::prod_type prod_ff  [4][3];
   hvt_pkg::prod_type prod_in  [4][3];
   hvt_pkg::data_type trans_ff [4];
   logic              v1_ff;

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         prod_in[c][0] = hvt_pkg::prod_type'(req_chan.in_x)
                       * hvt_pkg::prod_type'(coeff_ff[c]);
         prod_in[c][1] = hvt_pkg::prod_type'(req_chan.in_y)
                       * hvt_pkg::prod_type'(coeff_ff[4 + c]);
         prod_in[c][2] = hvt_pkg::prod_type'(req_chan.in_z)
                       * hvt_pkg::prod_type'(coeff_ff[8 + c]);
      end
   end

   // Stage 2: two partial sums per column.
   hvt_pkg::sum_type pa_ff [4];
   hvt_pkg::sum_type pb_ff [4];
   hvt_pkg::sum_type pa_in [4];
   hvt_pkg::sum_type pb_in [4];
   logic             v2_ff;

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         pa_in[c] = hvt_pkg::sum_type'(prod_ff[c][0]) + hvt_pkg::sum_type'(prod_ff[c][1]);
         pb_in[c] = hvt_pkg::sum_type'(prod_ff[c][2])
                  + (hvt_pkg::sum_type'(trans_ff[c]) <<< hvt_pkg::FRAC_BITS);
      end
   end

   // Stage 3: full sum, then the arithmetic shift back to FRAC_BITS fraction bits.
   hvt_pkg::coord_type coord_ff [4];
   hvt_pkg::coord_type coord_in [4];
   hvt_pkg::sum_type   sum_c    [4];
   logic               v3_ff;

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         sum_c[c]    = pa_ff[c] + pb_ff[c];
         coord_in[c] = sum_c[c][hvt_pkg::SUM_W-1:hvt_pkg::FRAC_BITS];
      end
   end

   // Stage 4: magnitudes and signs, the direct clamp for the w-zero case, and the
   // divider's starting remainder. The shifted numerator is split so that only 32
   // quotient bits are developed; a larger quotient is caught as overflow.
   hvt_pkg::div_type  div_ff  [NS+1][3];
   hvt_pkg::div_type  div_in  [NS+1][3];
   hvt_pkg::side_type side_ff [NS+1];
   hvt_pkg::side_type side_in;
   logic              vd_ff   [NS+1];

   always_comb begin
      logic                 wneg;
      logic                 xneg;
      logic                 fits;
      hvt_pkg::mag_type     xmag;
      hvt_pkg::coord_type   x;
      wneg            = coord_ff[3][CW-1];
      side_in.dmag    = wneg ? hvt_pkg::mag_type'(-coord_ff[3])
                             : hvt_pkg::mag_type'(coord_ff[3]);
      side_in.wz      = (coord_ff[3] == '0);
      side_in.csat    = 1'b0;
      side_in.clampv  = '0;
      for (int k = 0; k < 3; k++) begin
         x    = coord_ff[k];
         xneg = x[CW-1];
         xmag = xneg ? hvt_pkg::mag_type'(-x) : hvt_pkg::mag_type'(x);
         fits = (&x[CW-1:hvt_pkg::DATA_W-1]) || !(|x[CW-1:hvt_pkg::DATA_W-1]);
         side_in.clampv[k] = fits ? x[hvt_pkg::DATA_W-1:0]
                                  : (xneg ? hvt_pkg::NEG_LIMIT : hvt_pkg::POS_LIMIT);
         side_in.csat      = side_in.csat || !fits;
         div_in[0][k].rem  = xmag >> (hvt_pkg::DATA_W - hvt_pkg::FRAC_BITS);
         div_in[0][k].nlo  = {xmag[hvt_pkg::DATA_W-1-hvt_pkg::FRAC_BITS:0],
                              {hvt_pkg::FRAC_BITS{1'b0}}};
         div_in[0][k].q    = '0;
         div_in[0][k].neg  = xneg ^ wneg;
         div_in[0][k].ovf  = 1'b0;
      end
   end

   // Divider stages: each shifts in one numerator bit and decides one quotient bit.
   // The first stage also checks whether the quotient needs more than 32 bits.
   for (genvar i = 0; i < NS; i++) begin : g_div
      localparam int B = hvt_pkg::DATA_W - 1 - i;
      for (genvar k = 0; k < 3; k++) begin : g_lane
         logic [CW:0] tmp;
         logic [CW:0] diff;
         logic        ge;
         always_comb begin
            tmp  = {div_ff[i][k].rem, div_ff[i][k].nlo[B]};
            diff = tmp - {1'b0, side_ff[i].dmag};
            ge   = (tmp >= {1'b0, side_ff[i].dmag});
            div_in[i+1][k].rem = ge ? diff[CW-1:0] : tmp[CW-1:0];
            div_in[i+1][k].nlo = div_ff[i][k].nlo;
            div_in[i+1][k].q   = {div_ff[i][k].q[hvt_pkg::DATA_W-2:0], ge};
            div_in[i+1][k].neg = div_ff[i][k].neg;
            if (i == 0) begin
               div_in[i+1][k].ovf = (div_ff[i][k].rem >= side_ff[i].dmag);
            end else begin
               div_in[i+1][k].ovf = div_ff[i][k].ovf;
            end
         end
      end
   end

   // Final selection: clamp against the signed limit, apply the sign, or take the
   // direct clamp when w was zero.
   hvt_pkg::data_type     res_in [3];
   logic                  sat_in;

   always_comb begin
      logic [hvt_pkg::DATA_W-1:0] lim;
      logic [hvt_pkg::DATA_W-1:0] qs;
      logic                       over;
      logic                       any_over;
      any_over = 1'b0;
      for (int k = 0; k < 3; k++) begin
         lim  = div_ff[NS][k].neg ? hvt_pkg::NEG_LIMIT : hvt_pkg::POS_LIMIT;
         over = div_ff[NS][k].ovf || (div_ff[NS][k].q > lim);
         qs   = over ? lim : div_ff[NS][k].q;
         any_over = any_over || over;
         if (side_ff[NS].wz) begin
            res_in[k] = side_ff[NS].clampv[k];
         end else begin
            res_in[k] = div_ff[NS][k].neg ? -qs : qs;
         end
      end
      sat_in = side_ff[NS].wz ? side_ff[NS].csat : any_over;
   end

   // Pipeline registers.
   logic              out_valid_ff;
   hvt_pkg::data_type out_x_ff;
   hvt_pkg::data_type out_y_ff;
   hvt_pkg::data_type out_z_ff;
   logic              out_wz_ff;
   logic              out_sat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i <= NS; i++) begin
            vd_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         v1_ff        <= req_acc && req_chan.mode == hvt_pkg::MODE_XFORM;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         vd_ff[0]     <= v3_ff;
         for (int i = 0; i < NS; i++) begin
            vd_ff[i+1] <= vd_ff[i];
         end
         out_valid_ff <= vd_ff[NS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 3; r++) begin
               prod_ff[c][r] <= prod_in[c][r];
            end
            trans_ff[c] <= coeff_ff[12 + c];
            pa_ff[c]    <= pa_in[c];
            pb_ff[c]    <= pb_in[c];
            coord_ff[c] <= coord_in[c];
         end
         side_ff[0] <= side_in;
         for (int i = 0; i < NS; i++) begin
            side_ff[i+1] <= side_ff[i];
         end
         for (int i = 0; i <= NS; i++) begin
            for (int k = 0; k < 3; k++) begin
               div_ff[i][k] <= div_in[i][k];
            end
         end
         out_x_ff   <= res_in[0];
         out_y_ff   <= res_in[1];
         out_z_ff   <= res_in[2];
         out_wz_ff  <= side_ff[NS].wz;
         out_sat_ff <= sat_in;
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.out_x      = out_x_ff;
   assign rsp_chan.out_y      = out_y_ff;
   assign rsp_chan.out_z      = out_z_ff;
   assign rsp_chan.w_was_zero = out_wz_ff;
   assign rsp_chan.saturated  = out_sat_ff;

   // A load item must never start a result; a transform item always does.
   `HVT_ASSERT_NEXT(a_load_no_item, req_acc && req_chan.mode == hvt_pkg::MODE_LOAD, !v1_ff)
   `HVT_ASSERT_NEXT(a_xform_enters, req_acc && req_chan.mode == hvt_pkg::MODE_XFORM, v1_ff)
   // A stall freezes the last divider stage.
   `HVT_ASSERT_NEXT(a_stall_holds, !adv, $stable(vd_ff[NS]))
   // With w zero the divisor is zero, so the overflow check must fire.
   `HVT_ASSERT_IMP(a_wz_ovf, vd_ff[1] && side_ff[1].wz, div_ff[1][0].ovf)

endmodule

[tb/hvt_transform_checker.sv]
// Checker for the homogeneous vertex transform: watches both channels, keeps its own
// copy of the matrix, predicts each transform result and compares it in order.
// Depends on hvt_pkg and the channel interfaces in hvt_ifs.sv.
`timescale 1ns / 1ps

module hvt_transform_checker (
   input  logic      clock,
   input  logic      reset,
   hvt_req_if        req_chan,
   hvt_rsp_if        rsp_chan,
   output int        fail_count,
   output int        pending_count
);

   typedef struct {
      hvt_pkg::data_type x;
      hvt_pkg::data_type y;
      hvt_pkg::data_type z;
      logic              wz;
      logic              sat;
   } vertex_result_type;

   hvt_pkg::data_type matrix_copy [hvt_pkg::NUM_COEFF];
   vertex_result_type expected_vertices [$];

   // Exact dot product of (x, y, z, 1) with one column, shifted down by FRAC_BITS.
   function automatic logic signed [127:0] column_sum(input hvt_pkg::data_type px,
                                                      input hvt_pkg::data_type py,
                                                      input hvt_pkg::data_type pz,
                                                      input int col);
      logic signed [127:0] acc;
      acc = 128'(signed'(px)) * 128'(signed'(matrix_copy[col]))
          + 128'(signed'(py)) * 128'(signed'(matrix_copy[4 + col]))
          + 128'(signed'(pz)) * 128'(signed'(matrix_copy[8 + col]))
          + (128'(signed'(matrix_copy[12 + col])) <<< hvt_pkg::FRAC_BITS);
      return acc >>> hvt_pkg::FRAC_BITS;
   endfunction

   // Divide (or pass through when w is zero), truncate toward zero, clamp to 32 bits.
   function automatic hvt_pkg::data_type scale_coord(input logic signed [127:0] num,
                                                     input logic signed [127:0] den,
                                                     inout logic sat);
      logic signed [127:0] q;
      q = (den == 0) ? num : (num <<< hvt_pkg::FRAC_BITS) / den;
      if (q > 128'sd2147483647) begin
         sat = 1'b1;
         return hvt_pkg::POS_LIMIT;
      end
      if (q < -128'sd2147483648) begin
         sat = 1'b1;
         return hvt_pkg::NEG_LIMIT;
      end
      return hvt_pkg::data_type'(q[31:0]);
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch on %s: got %h, expected %h at %0t", what, got, want, $time);
      fail_count++;
   endtask

   always @(posedge clock) begin
      logic signed [127:0] cx, cy, cz, cw;
      vertex_result_type r;
      if (reset) begin
         foreach (matrix_copy[i]) matrix_copy[i] = '0;
         expected_vertices.delete();
         fail_count = 0;
      end else begin
         // Compare first: a result leaving never depends on an item entering now.
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_vertices.size() == 0) begin
               report_mismatch("unexpected result", 0, 0);
            end else begin
               r = expected_vertices.pop_front();
               if (rsp_chan.out_x !== r.x) report_mismatch("out_x", rsp_chan.out_x, r.x);
               if (rsp_chan.out_y !== r.y) report_mismatch("out_y", rsp_chan.out_y, r.y);
               if (rsp_chan.out_z !== r.z) report_mismatch("out_z", rsp_chan.out_z, r.z);
               if (rsp_chan.w_was_zero !== r.wz)
                  report_mismatch("w_was_zero", rsp_chan.w_was_zero, r.wz);
               if (rsp_chan.saturated !== r.sat)
                  report_mismatch("saturated", rsp_chan.saturated, r.sat);
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            if (req_chan.mode == hvt_pkg::MODE_LOAD) begin
               matrix_copy[req_chan.entry_index] = req_chan.entry_value;
            end else begin
               cx = column_sum(req_chan.in_x, req_chan.in_y, req_chan.in_z, 0);
               cy = column_sum(req_chan.in_x, req_chan.in_y, req_chan.in_z, 1);
               cz = column_sum(req_chan.in_x, req_chan.in_y, req_chan.in_z, 2);
               cw = column_sum(req_chan.in_x, req_chan.in_y, req_chan.in_z, 3);
               r.sat = 1'b0;
               r.wz  = (cw == 0);
               r.x   = scale_coord(cx, cw, r.sat);
               r.y   = scale_coord(cy, cw, r.sat);
               r.z   = scale_coord(cz, cw, r.sat);
               expected_vertices.push_back(r);
            end
         end
      end
      pending_count = expected_vertices.size();
   end
endmodule

[tb/homogeneous_vertex_transform_tb.sv]
// Top of the vertex transform testbench: clock, reset, stimulus, idling and verdict.
// Depends on hvt_pkg, hvt_ifs.sv, the block and hvt_transform_checker.sv.
`timescale 1ns / 1ps

module homogeneous_vertex_transform_tb;

   // Block latency from acceptance to result; the final wait before the verdict exceeds it.
   localparam int LATENCY     = 37;
   localparam int CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count;
   int   pending_count;
   int   cycle_count = 0;
   int   send_idle_pct = 0;
   int   recv_stall_pct = 0;
   bit   hold_off = 1'b0;

   hvt_req_if req_chan ();
   hvt_rsp_if rsp_chan ();

   homogeneous_vertex_transform DUT (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   hvt_transform_checker checker_inst (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_chan),
      .rsp_chan     (rsp_chan),
      .fail_count   (fail_count),
      .pending_count(pending_count)
   );

   always #4 clock = ~clock;

   // A timeout ends the run with a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // The receiver stalls at the current rate, or entirely while hold_off is set.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Random Q16.16 value: mostly small magnitudes so that divides stay in range, with
   // full-range values and the extremes mixed in to exercise saturation.
   function automatic hvt_pkg::data_type pick_value();
      case ($urandom_range(9))
         0: return hvt_pkg::data_type'($urandom);
         1: return hvt_pkg::POS_LIMIT;
         2: return hvt_pkg::NEG_LIMIT;
         3: return '0;
         default: return hvt_pkg::data_type'($urandom_range(32'h0006_0000))
                         - 32'sh0003_0000;
      endcase
   endfunction

   // Offers one item and holds it until accepted, idling at the current rate first.
   task automatic send_item(input logic mode, input logic [3:0] idx,
                            input hvt_pkg::data_type val, input hvt_pkg::data_type px,
                            input hvt_pkg::data_type py, input hvt_pkg::data_type pz);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.mode        <= mode;
      req_chan.entry_index <= idx;
      req_chan.entry_value <= val;
      req_chan.in_x        <= px;
      req_chan.in_y        <= py;
      req_chan.in_z        <= pz;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic load_entry(input logic [3:0] idx, input hvt_pkg::data_type val);
      send_item(hvt_pkg::MODE_LOAD, idx, val, hvt_pkg::data_type'($urandom),
                hvt_pkg::data_type'($urandom), hvt_pkg::data_type'($urandom));
   endtask

   task automatic transform_point(input hvt_pkg::data_type px, input hvt_pkg::data_type py,
                                  input hvt_pkg::data_type pz);
      send_item(hvt_pkg::MODE_XFORM, 4'($urandom), hvt_pkg::data_type'($urandom),
                px, py, pz);
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   initial begin
      int phase;
      req_chan.valid       <= 1'b0;
      req_chan.mode        <= hvt_pkg::MODE_LOAD;
      req_chan.entry_index <= '0;
      req_chan.entry_value <= '0;
      req_chan.in_x        <= '0;
      req_chan.in_y        <= '0;
      req_chan.in_z        <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. With the cleared matrix, w is zero and everything passes through.
      transform_point(hvt_pkg::POS_LIMIT, hvt_pkg::NEG_LIMIT, 32'sh0001_0000);
      // Identity matrix, loaded with entries back to back into a transform.
      for (int i = 0; i < 4; i++) load_entry(4'(i * 5), 32'sh0001_0000);
      transform_point(32'sh0002_8000, -32'sh0001_0000, 32'sh0000_0001);
      transform_point(hvt_pkg::POS_LIMIT, hvt_pkg::NEG_LIMIT, '0);
      // Perspective: w taken from z, so the divide happens; zero z gives w zero.
      load_entry(4'd15, '0);
      load_entry(4'd11, 32'sh0001_0000);
      transform_point(32'sh0004_0000, 32'sh0002_0000, 32'sh0002_0000);
      transform_point(32'sh0004_0000, -32'sh0002_0000, -32'sh0000_0001);
      transform_point(32'sh0004_0000, 32'sh0002_0000, '0);
      // Tiny w with large numerators saturates in both directions.
      transform_point(hvt_pkg::POS_LIMIT, hvt_pkg::NEG_LIMIT, 32'sh0000_0001);
      // Extreme coefficients in every third entry, with extreme points.
      for (int i = 0; i < 16; i += 3)
         load_entry(4'(i), (i % 2) ? hvt_pkg::NEG_LIMIT : hvt_pkg::POS_LIMIT);
      transform_point(hvt_pkg::NEG_LIMIT, hvt_pkg::NEG_LIMIT, hvt_pkg::NEG_LIMIT);
      transform_point(hvt_pkg::POS_LIMIT, hvt_pkg::POS_LIMIT, hvt_pkg::POS_LIMIT);
      drain();

      // Random phases: no idling, sender idle, receiver stalling, both.
      for (phase = 0; phase < 4; phase++) begin
         send_idle_pct  = (phase == 1) ? 70 : (phase == 3) ? 12 : 0;
         recv_stall_pct = (phase == 2) ? 70 : (phase == 3) ? 12 : 0;
         for (int n = 0; n < 420; n++) begin
            // Occasional matrix updates, mostly point streams.
            if ($urandom_range(99) < 8) begin
               load_entry(4'($urandom), pick_value());
            end else if ($urandom_range(99) < 2) begin
               // Make w zero for a while by clearing the last column.
               for (int r = 0; r < 4; r++) load_entry(4'(r * 4 + 3), '0);
            end else begin
               transform_point(pick_value(), pick_value(), pick_value());
            end
         end
         if (phase == 1) begin
            // Long receiver hold-off while items keep coming, so the input stalls.
            hold_off = 1'b1;
            fork
               begin
                  repeat (300) @(posedge clock);
                  hold_off = 1'b0;
               end
               for (int n = 0; n < 80; n++)
                  transform_point(pick_value(), pick_value(), pick_value());
            join
         end
         // Sender pauses until every expected result has come.
         drain();
      end

      repeat (LATENCY + 10) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule

[filelist.f]
+incdir+design
design/hvt_pkg.sv
design/hvt_ifs.sv
design/homogeneous_vertex_transform.sv
tb/hvt_transform_checker.sv
tb/homogeneous_vertex_transform_tb.sv
